### src/deq_pkg.sv
package deq_pkg;

   // Field widths of one transaction on either side.
   localparam int CMD_W   = 3;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   // Stream data widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 112;
   localparam int REQ_PAD_W   = REQ_TDATA_W - CMD_W - DATA_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 3 * DATA_W - COUNT_W - 3;

   // Command codes carried in the request.
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

   // Word reported for an empty end or a step that popped nothing.
   localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

   // What a step actually did to the deque after the full and empty checks.
   typedef enum logic [2:0] {
      KIND_QUERY,
      KIND_PUSH_FRONT,
      KIND_PUSH_BACK,
      KIND_POP_FRONT,
      KIND_POP_BACK
   } kind_type;

   // One step handed from the index tracker to the result stage.
   typedef struct packed {
      kind_type                  kind;
      logic signed [DATA_W-1:0]  value;
      logic signed [DATA_W-1:0]  popped;
      logic                      push_dropped;
      logic                      is_empty;
      logic                      single;
   } item_type;

   // One result transaction.
   typedef struct packed {
      logic signed [DATA_W-1:0]  popped_value;
      logic                      pop_done;
      logic signed [DATA_W-1:0]  front_value;
      logic signed [DATA_W-1:0]  back_value;
      logic [COUNT_W-1:0]        count;
      logic                      is_empty;
      logic                      push_dropped;
   } rsp_type;

endpackage

### src/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit words, DEPTH entries deep. Each
// request transaction carries a command (push front, push back, pop front, pop
// back, or query; unused codes act as query) and a word, and yields exactly one
// response transaction with the popped word, the front and back words, the
// count and the empty, pop-done and push-dropped flags. A request is taken when no
// step is held or the held step moves on: the indices and count update on the
// accept edge, the store has one write port and one registered read port, and the
// front and back words are kept in registers so each step touches at most one
// store entry. An accepted request is held in the step register and then in the
// response register, and the core sustains one transaction per cycle while the
// response side is ready. The store needs no clearing after reset.
module double_ended_queue_core #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: command[2:0], value[34:3], zero pad[39:35].
   input  logic [deq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: popped_value[31:0], pop_done[32], front_value[64:33],
   // back_value[96:65], count[107:97], is_empty[108], push_dropped[109],
   // zero pad[111:110].
   output logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                     accept;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] value;
   logic signed [DATA_W-1:0] front_now, back_now;
   logic                     wr_en, rd_en;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic [DATA_W-1:0]        wr_data, rd_data;
   item_type                 step;
   logic [CNT_W-1:0]         cnt_after;
   rsp_type                  rsp;

   assign accept  = req_tvalid && req_tready;
   assign command = req_tdata[CMD_W-1:0];
   assign value   = req_tdata[CMD_W +: DATA_W];

   deq_track #(.DEPTH(DEPTH)) u_track (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (command),
      .value     (value),
      .front_now (front_now),
      .back_now  (back_now),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .step      (step),
      .cnt_after (cnt_after)
   );

   deq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   deq_result #(.DEPTH(DEPTH)) u_result (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ready     (req_tready),
      .step      (step),
      .cnt_after (cnt_after),
      .rd_data   (rd_data),
      .front_now (front_now),
      .back_now  (back_now),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.push_dropped, rsp.is_empty, rsp.count,
                       rsp.back_value, rsp.front_value, rsp.pop_done, rsp.popped_value};

endmodule

### src/deq_store.sv
module deq_store #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [deq_pkg::DATA_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [deq_pkg::DATA_W-1:0]    rd_data
);
   import deq_pkg::*;

   logic [DATA_W-1:0] words_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= words_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/deq_track.sv
module deq_track #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [deq_pkg::CMD_W-1:0]          command,
   input  logic signed [deq_pkg::DATA_W-1:0]  value,
   input  logic signed [deq_pkg::DATA_W-1:0]  front_now,
   input  logic signed [deq_pkg::DATA_W-1:0]  back_now,
   output logic                               wr_en,
   output logic [$clog2(DEPTH)-1:0]           wr_addr,
   output logic [deq_pkg::DATA_W-1:0]         wr_data,
   output logic                               rd_en,
   output logic [$clog2(DEPTH)-1:0]           rd_addr,
   output deq_pkg::item_type                  step,
   output logic [$clog2(DEPTH+1)-1:0]         cnt_after
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [IDX_W-1:0] front_idx_ff, front_idx_in;
   logic [IDX_W-1:0] back_idx_ff, back_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] front_dec, front_inc, back_dec, back_inc;
   logic             full, empty, dropped;
   kind_type         kind;

   // Neighbor slots of both ends, wrapping around the circular store.
   assign front_dec = (front_idx_ff == '0) ? LAST_IDX : front_idx_ff - IDX_W'(1);
   assign front_inc = (front_idx_ff == LAST_IDX) ? '0 : front_idx_ff + IDX_W'(1);
   assign back_dec  = (back_idx_ff == '0) ? LAST_IDX : back_idx_ff - IDX_W'(1);
   assign back_inc  = (back_idx_ff == LAST_IDX) ? '0 : back_idx_ff + IDX_W'(1);

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // Resolve the command against the full and empty conditions.
   always_comb begin
      kind    = KIND_QUERY;
      dropped = 1'b0;
      unique case (command)
         CMD_PUSH_FRONT: begin
            if (full) dropped = 1'b1;
            else      kind    = KIND_PUSH_FRONT;
         end
         CMD_PUSH_BACK: begin
            if (full) dropped = 1'b1;
            else      kind    = KIND_PUSH_BACK;
         end
         CMD_POP_FRONT: begin
            if (!empty) kind = KIND_POP_FRONT;
         end
         CMD_POP_BACK: begin
            if (!empty) kind = KIND_POP_BACK;
         end
         default: begin
            kind = KIND_QUERY;
         end
      endcase
   end

   // Index and count updates; the back index always lies count - 1 slots past the front, wrapping.
   always_comb begin
      front_idx_in = front_idx_ff;
      back_idx_in  = back_idx_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = front_dec;
      rd_en        = 1'b0;
      rd_addr      = front_inc;
      unique case (kind)
         KIND_PUSH_FRONT: begin
            front_idx_in = front_dec;
            count_in     = count_ff + CNT_W'(1);
            wr_en        = accept;
            wr_addr      = front_dec;
         end
         KIND_PUSH_BACK: begin
            back_idx_in = back_inc;
            count_in    = count_ff + CNT_W'(1);
            wr_en       = accept;
            wr_addr     = back_inc;
         end
         KIND_POP_FRONT: begin
            front_idx_in = front_inc;
            count_in     = count_ff - CNT_W'(1);
            rd_en        = accept;
            rd_addr      = front_inc;
         end
         KIND_POP_BACK: begin
            back_idx_in = back_dec;
            count_in    = count_ff - CNT_W'(1);
            rd_en       = accept;
            rd_addr     = back_dec;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign wr_data = value;

   // Step summary for the result stage.
   always_comb begin
      step.kind         = kind;
      step.value        = value;
      step.push_dropped = dropped;
      step.is_empty     = (count_in == '0);
      step.single       = (count_in == CNT_W'(1));
      if (kind == KIND_POP_FRONT)     step.popped = front_now;
      else if (kind == KIND_POP_BACK) step.popped = back_now;
      else                            step.popped = EMPTY_WORD;
   end

   assign cnt_after = count_in;

   // State advances on every accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_idx_ff <= '0;
         back_idx_ff  <= LAST_IDX;
         count_ff     <= '0;
      end else if (accept) begin
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         count_ff     <= count_in;
      end
   end

endmodule

### src/deq_result.sv
module deq_result #(
   parameter int DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   output logic                               ready,
   input  deq_pkg::item_type                  step,
   input  logic [$clog2(DEPTH+1)-1:0]         cnt_after,
   input  logic [deq_pkg::DATA_W-1:0]         rd_data,
   output logic signed [deq_pkg::DATA_W-1:0]  front_now,
   output logic signed [deq_pkg::DATA_W-1:0]  back_now,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output deq_pkg::rsp_type                   rsp
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                     item_valid_ff, item_valid_in;
   item_type                 item_ff;
   logic [CNT_W-1:0]         item_cnt_ff;
   logic signed [DATA_W-1:0] front_ff, back_ff;
   logic signed [DATA_W-1:0] front_calc, back_calc;
   logic signed [DATA_W-1:0] mem_word;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     take;

   assign mem_word = rd_data;

   // The held step moves on when the result register is free or being drained.
   assign take  = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign ready = !item_valid_ff || take;

   // End values after the held step; a popped end is refilled from the store.
   always_comb begin
      front_calc = front_ff;
      back_calc  = back_ff;
      unique case (item_ff.kind)
         KIND_PUSH_FRONT: begin
            front_calc = item_ff.value;
            if (item_ff.single) back_calc = item_ff.value;
         end
         KIND_PUSH_BACK: begin
            back_calc = item_ff.value;
            if (item_ff.single) front_calc = item_ff.value;
         end
         KIND_POP_FRONT: begin
            front_calc = mem_word;
         end
         KIND_POP_BACK: begin
            back_calc = mem_word;
         end
         default: begin
            front_calc = front_ff;
         end
      endcase
      if (item_ff.is_empty) begin
         front_calc = EMPTY_WORD;
         back_calc  = EMPTY_WORD;
      end
   end

   // Current ends as seen by the next transaction.
   assign front_now = item_valid_ff ? front_calc : front_ff;
   assign back_now  = item_valid_ff ? back_calc : back_ff;

   // Result transaction built from the held step.
   always_comb begin
      rsp_in.popped_value = item_ff.popped;
      rsp_in.pop_done     = (item_ff.kind == KIND_POP_FRONT) ||
                            (item_ff.kind == KIND_POP_BACK);
      rsp_in.front_value  = front_calc;
      rsp_in.back_value   = back_calc;
      rsp_in.count        = COUNT_W'(item_cnt_ff);
      rsp_in.is_empty     = item_ff.is_empty;
      rsp_in.push_dropped = item_ff.push_dropped;
   end

   always_comb begin
      if (accept)    item_valid_in = 1'b1;
      else if (take) item_valid_in = 1'b0;
      else           item_valid_in = item_valid_ff;
   end

   always_comb begin
      if (take)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // Control registers and cached end words.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         front_ff      <= EMPTY_WORD;
         back_ff       <= EMPTY_WORD;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (take) begin
            front_ff <= front_calc;
            back_ff  <= back_calc;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff     <= step;
         item_cnt_ff <= cnt_after;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // A held step is never overwritten before it moves on.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (!item_valid_ff || take))
      else $error("step register overwritten while still held");

   // A step that moves on always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("step moved on without producing a result");

   // An empty deque reports both ends as the empty word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_empty) |->
         (rsp_ff.front_value == EMPTY_WORD && rsp_ff.back_value == EMPTY_WORD))
      else $error("empty result shows a stored word");

   // A pop and a dropped push never happen in the same step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.pop_done && rsp_ff.push_dropped))
      else $error("result flags both a pop and a dropped push");

endmodule
